// File: src/mandelbrot_escape_time_pixel_unit_defines.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel unit: assertion macros
// Concurrent checks clocked by i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MBET_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mbet check failed");
`define MBET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mbet check failed");
`else
`define MBET_ASSERT_SAME(label, ante, cons)
`define MBET_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/mbet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types, constants and fixed-point helpers of the escape-time unit.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int WIDTH     = 800;
    localparam int HEIGHT    = 600;
    localparam int FRAC_BITS = 24;

    localparam int Q_W      = 32;
    localparam int STEP_W   = 25;
    localparam int LIMIT_W  = 31;
    localparam int ITER_W   = 8;
    localparam int COORD_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int OFS_W  = COORD_W + 3;
    localparam int MAP_W  = OFS_W + STEP_W + 1;
    localparam int PROD_W = 2 * Q_W - FRAC_BITS;
    localparam int WIDE_W = PROD_W + 1;

    localparam logic [OFS_W-1:0] HALF_WIDTH  = OFS_W'(WIDTH / 2);
    localparam logic [OFS_W-1:0] HALF_HEIGHT = OFS_W'(HEIGHT / 2);

    localparam logic signed [Q_W-1:0] CENTER_RE_RST = '0;
    localparam logic signed [Q_W-1:0] CENTER_IM_RST = '0;
    localparam logic [STEP_W-1:0]     STEP_RST      = STEP_W'(167772);
    localparam logic [LIMIT_W-1:0]    LIMIT_RST     = LIMIT_W'(167772160);
    localparam logic [ITER_W-1:0]     MAX_ITER_RST  = ITER_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_RE  = 3'd0,
        REG_CENTER_IM  = 3'd1,
        REG_PIXEL_STEP = 3'd2,
        REG_ESC_LIMIT  = 3'd3,
        REG_MAX_ITER   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [Q_W-1:0] center_re;
        logic signed [Q_W-1:0] center_im;
        logic [STEP_W-1:0]     pixel_step;
        logic [LIMIT_W-1:0]    escape_limit;
        logic [ITER_W-1:0]     max_iterations;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic seed;
        logic mult;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic cap_hit;
        logic escaped;
    } t_dp_status;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = {{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
        lo = {{(WIDE_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
        if (v > hi) begin
            return hi[Q_W-1:0];
        end else if (v < lo) begin
            return lo[Q_W-1:0];
        end
        return v[Q_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] v);
        return v[Q_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// File: src/mbet_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_cfg
// Configuration register file: view center, pixel step, escape limit, cap.
// ----------------------------------------------------------------------------
module mbet_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbet_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output mbet_pkg::t_cfg                  o_cfg
);
    import mbet_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_re      <= CENTER_RE_RST;
            r_cfg.center_im      <= CENTER_IM_RST;
            r_cfg.pixel_step     <= STEP_RST;
            r_cfg.escape_limit   <= LIMIT_RST;
            r_cfg.max_iterations <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CENTER_RE:  r_cfg.center_re      <= $signed(i_cfg_wdata[Q_W-1:0]);
                REG_CENTER_IM:  r_cfg.center_im      <= $signed(i_cfg_wdata[Q_W-1:0]);
                REG_PIXEL_STEP: r_cfg.pixel_step     <= i_cfg_wdata[STEP_W-1:0];
                REG_ESC_LIMIT:  r_cfg.escape_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                REG_MAX_ITER:   r_cfg.max_iterations <= i_cfg_wdata[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/mbet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_ctrl
// Sequencer: load pixel, seed c and z, alternate multiply and update steps.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_unit_defines.svh"

module mbet_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  mbet_pkg::t_dp_status i_status,
    output mbet_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_done
);
    import mbet_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_MUL,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.seed   = (r_state == S_SEED);
        o_cmd.mult   = (r_state == S_MUL) && !i_status.cap_hit;
        o_cmd.update = (r_state == S_UPD) && !i_status.escaped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SEED;
                        r_busy  <= 1'b1;
                    end
                end
                S_SEED: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (i_status.cap_hit) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (i_status.escaped) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

    `MBET_ASSERT_NEXT(a_accept_sets_busy, i_start && !r_busy, r_busy && (r_state == S_SEED))
    `MBET_ASSERT_SAME(a_done_after_work, r_done, !r_busy && $past(r_busy))
    `MBET_ASSERT_SAME(a_busy_matches_state, 1'b1, r_busy == (r_state != S_IDLE))
    `MBET_ASSERT_NEXT(a_done_single, r_done, !r_done)

endmodule

// File: src/mbet_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_dp
// Datapath: pixel-to-point mapping, squaring and cross products, escape test, z update.
// ----------------------------------------------------------------------------
module mbet_dp (
    input  logic                          i_clk,
    input  mbet_pkg::t_cfg                i_cfg,
    input  mbet_pkg::t_dp_cmd             i_cmd,
    input  logic [mbet_pkg::COORD_W-1:0]  i_pixel_col,
    input  logic [mbet_pkg::COORD_W-1:0]  i_pixel_row,
    output mbet_pkg::t_dp_status          o_status,
    output logic [mbet_pkg::ITER_W-1:0]   o_count
);
    import mbet_pkg::*;

    logic signed [OFS_W-1:0]    off_col;
    logic signed [OFS_W-1:0]    off_row;
    logic signed [STEP_W:0]     step_s;
    logic signed [WIDE_W-1:0]   seed_re_w;
    logic signed [WIDE_W-1:0]   seed_im_w;
    logic [Q_W-1:0]             mag_re;
    logic [Q_W-1:0]             mag_im;
    logic [2*Q_W-1:0]           prod_re2;
    logic [2*Q_W-1:0]           prod_im2;
    logic [2*Q_W-1:0]           prod_x;
    logic [WIDE_W-1:0]          radius2;
    logic signed [WIDE_W-1:0]   cross_w;
    logic signed [WIDE_W-1:0]   next_re_w;
    logic signed [WIDE_W-1:0]   next_im_w;
    logic signed [WIDE_W-1:0]   c_re_w;
    logic signed [WIDE_W-1:0]   c_im_w;

    logic signed [MAP_W-1:0]    r_map_re;
    logic signed [MAP_W-1:0]    r_map_im;
    logic signed [Q_W-1:0]      r_c_re;
    logic signed [Q_W-1:0]      r_c_im;
    logic signed [Q_W-1:0]      r_z_re;
    logic signed [Q_W-1:0]      r_z_im;
    logic [PROD_W-1:0]          r_re2;
    logic [PROD_W-1:0]          r_im2;
    logic [PROD_W-1:0]          r_xm;
    logic                       r_xneg;
    logic [ITER_W-1:0]          r_count;

    assign off_col = $signed({{(OFS_W-COORD_W){1'b0}}, i_pixel_col}) - $signed(HALF_WIDTH);
    assign off_row = $signed({{(OFS_W-COORD_W){1'b0}}, i_pixel_row}) - $signed(HALF_HEIGHT);
    assign step_s  = $signed({1'b0, i_cfg.pixel_step});

    assign seed_re_w = {{(WIDE_W-MAP_W){r_map_re[MAP_W-1]}}, r_map_re}
                     + {{(WIDE_W-Q_W){i_cfg.center_re[Q_W-1]}}, i_cfg.center_re};
    assign seed_im_w = {{(WIDE_W-MAP_W){r_map_im[MAP_W-1]}}, r_map_im}
                     + {{(WIDE_W-Q_W){i_cfg.center_im[Q_W-1]}}, i_cfg.center_im};

    assign mag_re   = mag_q(r_z_re);
    assign mag_im   = mag_q(r_z_im);
    assign prod_re2 = {{Q_W{1'b0}}, mag_re} * {{Q_W{1'b0}}, mag_re};
    assign prod_im2 = {{Q_W{1'b0}}, mag_im} * {{Q_W{1'b0}}, mag_im};
    assign prod_x   = {{Q_W{1'b0}}, mag_re} * {{Q_W{1'b0}}, mag_im};

    assign c_re_w    = {{(WIDE_W-Q_W){r_c_re[Q_W-1]}}, r_c_re};
    assign c_im_w    = {{(WIDE_W-Q_W){r_c_im[Q_W-1]}}, r_c_im};
    assign radius2   = {1'b0, r_re2} + {1'b0, r_im2};
    assign cross_w   = r_xneg ? -$signed({1'b0, r_xm}) : $signed({1'b0, r_xm});
    assign next_re_w = $signed({1'b0, r_re2}) - $signed({1'b0, r_im2}) + c_re_w;
    assign next_im_w = (cross_w <<< 1) + c_im_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_map_re <= off_col * step_s;
            r_map_im <= off_row * step_s;
        end
        if (i_cmd.seed) begin
            r_c_re  <= sat_q(seed_re_w);
            r_c_im  <= sat_q(seed_im_w);
            r_z_re  <= sat_q(seed_re_w);
            r_z_im  <= sat_q(seed_im_w);
            r_count <= '0;
        end
        if (i_cmd.mult) begin
            r_re2  <= prod_re2[2*Q_W-1:FRAC_BITS];
            r_im2  <= prod_im2[2*Q_W-1:FRAC_BITS];
            r_xm   <= prod_x[2*Q_W-1:FRAC_BITS];
            r_xneg <= r_z_re[Q_W-1] ^ r_z_im[Q_W-1];
        end
        if (i_cmd.update) begin
            r_z_re  <= sat_q(next_re_w);
            r_z_im  <= sat_q(next_im_w);
            r_count <= r_count + 1'b1;
        end
    end

    assign o_status.cap_hit = (r_count == i_cfg.max_iterations);
    assign o_status.escaped = (radius2 > {{(WIDE_W-LIMIT_W){1'b0}}, i_cfg.escape_limit});
    assign o_count          = r_count;

endmodule

// File: src/mandelbrot_escape_time_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit
// Maps a screen pixel to a point c and returns its escape-time count.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high while busy is low; busy then stays high
// until the result. One pixel is worked at a time. The result on o_intensity
// is flagged by o_valid for exactly one cycle, and must be captured then: it
// cannot be held off. o_valid rises once the pixel escapes or its count
// reaches the iteration cap. Each iteration has a multiply step for the two
// 32x32 squaring products and the 32x32 cross product, then an update step
// for the escape test and the z update. busy falls in the same cycle that
// o_valid is shown, so the next pixel may be taken then. Configuration
// writes land at once and must be made while busy is low.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mbet_pkg::COORD_W-1:0]    i_pixel_col,
    input  logic [mbet_pkg::COORD_W-1:0]    i_pixel_row,
    output logic                            o_valid,
    output logic [mbet_pkg::ITER_W-1:0]     o_intensity,
    input  logic                            i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbet_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import mbet_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mbet_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mbet_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_done   (o_valid)
    );

    mbet_dp u_dp (
        .i_clk       (i_clk),
        .i_cfg       (cfg),
        .i_cmd       (dp_cmd),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .o_status    (dp_status),
        .o_count     (o_intensity)
    );

endmodule
